// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, command and status codes, and the per-cycle control
// bundle that the list controller broadcasts to the cell chain.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int POS_W  = 10;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// Broadcast to every cell in the chain each cycle
	typedef struct packed {
		logic              ins;   // insert shift enable
		logic              del;   // delete shift enable
		logic [POS_W-1:0]  pidx;  // 0-based target slot
		logic [DATA_W-1:0] val;   // word to insert
	} cell_ctrl_t;

endpackage

// ===== rtl/ple_if.sv =====
// ----------------------------------------------------------------------------
// ple_if
// Valid/ready channels for list commands and list results.
// ----------------------------------------------------------------------------
interface ple_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [9:0]               position;
	logic signed [31:0]       value_in;

	modport source (output valid, cmd, position, value_in, input ready);
	modport sink   (input valid, cmd, position, value_in, output ready);
endinterface

interface ple_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [31:0]       value_out;
	logic [9:0]               length;

	modport source (output valid, status, value_out, length, input ready);
	modport sink   (input valid, status, value_out, length, output ready);
endinterface

// ===== rtl/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed words with get/insert/delete/clear.
// ----------------------------------------------------------------------------
// Every cell of the chain shifts in parallel in the cycle a command is
// accepted, and the result is registered and shown the next cycle. One
// command is accepted per cycle as long as the result side takes each
// item; a held result blocks new commands until it is taken. Positions
// are 1-based; get and delete accept 1..length, insert accepts
// 1..length+1. An insert at a valid position into a full list reports
// full and leaves the list unchanged. Words stored at reset are undefined;
// only written slots are ever read.
module positional_list_engine_core
	import ple_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	ple_cmd_if.sink   req,
	ple_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic              accept;
	cmd_t              cmd;
	logic [POS_W-1:0]  cnt_ext;
	logic              pos_zero;
	logic              bad_rd;
	logic              bad_ins;
	logic              full;
	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] rd_data;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              out_valid_q;
	status_t           status_q;
	status_t           status_d;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] value_d;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cmd       = cmd_t'(req.cmd);

	// Position checks
	assign cnt_ext  = POS_W'(count_q);
	assign pos_zero = (req.position == '0);
	assign bad_rd   = pos_zero || (req.position > cnt_ext);
	assign bad_ins  = pos_zero ||
		({1'b0, req.position} > ({1'b0, cnt_ext} + (POS_W+1)'(1)));
	assign full     = (count_q == CNT_W'(DEPTH));

	// Chain control
	always_comb begin
		ctrl.ins  = accept && (cmd == CMD_INSERT) && !bad_ins && !full;
		ctrl.del  = accept && (cmd == CMD_DELETE) && !bad_rd;
		ctrl.pidx = req.position - POS_W'(1);
		ctrl.val  = req.value_in;
	end

	ple_chain #(.DEPTH(DEPTH)) u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.rd_data (rd_data)
	);

	// Result and next length
	always_comb begin
		status_d = ST_OK;
		value_d  = '0;
		count_d  = count_q;
		unique case (cmd)
			CMD_GET: begin
				if (bad_rd)
					status_d = ST_BADPOS;
				else
					value_d = rd_data;
			end
			CMD_INSERT: begin
				if (bad_ins)
					status_d = ST_BADPOS;
				else if (full)
					status_d = ST_FULL;
				else
					count_d = count_q + CNT_W'(1);
			end
			CMD_DELETE: begin
				if (bad_rd) begin
					status_d = ST_BADPOS;
				end else begin
					value_d = rd_data;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				count_q <= count_d;
			if (accept)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			value_q  <= value_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.value_out = value_q;
	assign rsp.length    = POS_W'(count_q);

endmodule

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. Loads the inserted word, takes its left neighbor on an
// insert shift or its right neighbor on a delete shift, else holds.
// ----------------------------------------------------------------------------
module ple_cell
	import ple_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] rd
);

	localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

	logic              here;
	logic              after;
	logic [DATA_W-1:0] word_q;

	assign here  = (IDX_V == ctrl.pidx);
	assign after = (IDX_V > ctrl.pidx);

	// Slot update
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (here)
				word_q <= ctrl.val;
			else if (after)
				word_q <= left;
		end else if (ctrl.del) begin
			if (here || after)
				word_q <= right;
		end
	end

	assign data = word_q;
	// Masked read; OR-combined across the chain
	assign rd = here ? word_q : '0;

endmodule

// ===== rtl/ple_chain.sv =====
// ----------------------------------------------------------------------------
// ple_chain
// Row of DEPTH cells wired to their neighbors, plus the read combine.
// ----------------------------------------------------------------------------
module ple_chain
	import ple_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] word [DEPTH];
	logic [DATA_W-1:0] rd   [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = word[i];
		end else begin : g_mid_r
			assign right_w = word[i+1];
		end

		ple_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_w),
			.right (right_w),
			.data  (word[i]),
			.rd    (rd[i])
		);
	end

	// At most one cell matches the target slot
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++)
			rd_data = rd_data | rd[i];
	end

endmodule

// ===== rtl/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker
	import ple_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_cmd,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_value_out,
	input logic [9:0]  rsp_length
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// Every accepted command shows a result the next cycle
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("no result after accepted command");

	// Clear empties the list and reports ok
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_cmd == CMD_CLEAR) |=>
			(rsp_length == '0 && rsp_status == ST_OK && rsp_value_out == '0))
		else $error("clear result wrong");

	// Length never exceeds capacity and status is a defined code
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_length <= 10'(DEPTH) && rsp_status != 2'd3))
		else $error("length or status out of range");

	// Failed commands return no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status == ST_BADPOS || rsp_status == ST_FULL))
			|-> rsp_value_out == '0)
		else $error("nonzero value on failed command");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_status) && $stable(rsp_value_out)
			 && $stable(rsp_length)))
		else $error("stalled result changed");

endmodule

bind positional_list_engine_core ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_cmd       (req.cmd),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_value_out (rsp.value_out),
	.rsp_length    (rsp.length)
);
